### sv/lrdda_pkg.sv
// shared constants, types and helpers for the line rasterizer
package lrdda_pkg;

    localparam int IN_W      = 8;
    localparam int PIX_W     = 6;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    localparam int SIDE_DEF      = 64;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [CFG_W-1:0] CANVAS_RESET = 7'd64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH  = 1'b0,
        CFG_SCREEN_HEIGHT = 1'b1
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DRAW = 3'b100
    } t_state;

    // canvas side as seen by the bounds check: register value capped at the side
    function automatic logic [CFG_W-1:0] canvas_limit(
        input logic [CFG_W-1:0] lim_reg,
        input logic [CFG_W-1:0] side_cap
    );
        return (lim_reg > side_cap) ? side_cap : lim_reg;
    endfunction

endpackage

### sv/line_rasterizer_dda_top.sv
// line rasterizer: bounds check, bit-serial slope divider and major-axis stepper
//
// One input transaction carries a line request (start and end point). If either
// point falls outside the canvas, or both points coincide, the request is dropped
// with no pixels. Otherwise the block registers the request in setup, runs the
// restoring divider that forms the slope one quotient bit per cycle, then emits
// one pixel per cycle while the output is not stalled, along the longer axis,
// |long span| pixels in all (at most SIDE-1), the end point excluded and the
// final pixel flagged with last_pixel. The input is stalled after setup until
// the last pixel has been loaded into the output register. Canvas registers are
// written through the configuration channel, which is always ready; write them
// only while idle.
module line_rasterizer_dda_top #(
    parameter int SIDE      = lrdda_pkg::SIDE_DEF,
    parameter int FRAC_BITS = lrdda_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lrdda_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lrdda_pkg::CFG_W-1:0]     i_cfg_data,
    // line request
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic signed [lrdda_pkg::IN_W-1:0] i_start_x,
    input  logic signed [lrdda_pkg::IN_W-1:0] i_start_y,
    input  logic signed [lrdda_pkg::IN_W-1:0] i_end_x,
    input  logic signed [lrdda_pkg::IN_W-1:0] i_end_y,
    // pixels
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [lrdda_pkg::PIX_W-1:0]     o_pixel_x,
    output logic [lrdda_pkg::PIX_W-1:0]     o_pixel_y,
    output logic                            o_last_pixel
);

    localparam int PW    = lrdda_pkg::PIX_W;
    localparam int CW    = lrdda_pkg::CFG_W;
    localparam int QW    = FRAC_BITS + 1;
    localparam int AW    = FRAC_BITS + PW;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam logic [CW-1:0]    SIDE_LIM  = CW'(SIDE);
    localparam logic [CNT_W-1:0] CNT_START = CNT_W'(FRAC_BITS);

    lrdda_pkg::t_state r_state, n_state;

    logic [CW-1:0]    r_width, r_height;
    logic [PW-1:0]    r_x0, r_y0;
    logic             r_major_y, r_dir, r_minor_neg;
    logic [PW-1:0]    r_mag_l;
    logic [PW:0]      r_rem;
    logic [QW-1:0]    r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic [AW-1:0]    r_acc;
    logic [PW-1:0]    r_k;
    logic             r_out_valid;
    logic [PW-1:0]    r_pix_x, r_pix_y;
    logic             r_last;

    // request decode
    logic          in_acc, out_acc, in_ok, start_draw;
    logic [CW-1:0] lim_w, lim_h;
    logic [PW:0]   dx, dy, ndx, ndy;
    logic [PW-1:0] adx, ady, mag_l, mag_s;
    logic          major_y, dir, minor_neg;

    // divider step
    logic [PW:0] shifted, rem_n;
    logic        q_bit;

    // pixel step
    logic          emit, last_now;
    logic [PW-1:0] off, minor_x, minor_y, major_x, major_y_c;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != lrdda_pkg::ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = r_out_valid && !i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_pixel_x    = r_pix_x;
    assign o_pixel_y    = r_pix_y;
    assign o_last_pixel = r_last;

    always_comb begin
        lim_w = lrdda_pkg::canvas_limit(r_width, SIDE_LIM);
        lim_h = lrdda_pkg::canvas_limit(r_height, SIDE_LIM);
        in_ok = !i_start_x[7] && (i_start_x[6:0] < lim_w)
             && !i_start_y[7] && (i_start_y[6:0] < lim_h)
             && !i_end_x[7]   && (i_end_x[6:0]   < lim_w)
             && !i_end_y[7]   && (i_end_y[6:0]   < lim_h);

        // both points are on the canvas here, so 6 bits carry each coordinate
        dx  = {1'b0, i_end_x[PW-1:0]} - {1'b0, i_start_x[PW-1:0]};
        dy  = {1'b0, i_end_y[PW-1:0]} - {1'b0, i_start_y[PW-1:0]};
        ndx = -dx;
        ndy = -dy;
        adx = dx[PW] ? ndx[PW-1:0] : dx[PW-1:0];
        ady = dy[PW] ? ndy[PW-1:0] : dy[PW-1:0];

        major_y   = (ady > adx);
        mag_l     = major_y ? ady : adx;
        mag_s     = major_y ? adx : ady;
        dir       = major_y ? dy[PW] : dx[PW];
        minor_neg = major_y ? dx[PW] : dy[PW];

        start_draw = in_acc && in_ok && (mag_l != '0);
    end

    // restoring division: first step compares without shifting
    always_comb begin
        shifted = (r_cnt == CNT_START) ? r_rem : {r_rem[PW-1:0], 1'b0};
        q_bit   = (shifted >= {1'b0, r_mag_l});
        rem_n   = q_bit ? (shifted - {1'b0, r_mag_l}) : shifted;
    end

    always_comb begin
        emit     = (r_state == lrdda_pkg::ST_DRAW) && (!r_out_valid || !i_out_stall);
        last_now = (r_k == (r_mag_l - PW'(1)));
        off      = r_acc[AW-1:FRAC_BITS];
        // minor offset magnitude is truncated, the sign applied afterwards
        minor_x   = r_minor_neg ? (r_x0 - off) : (r_x0 + off);
        minor_y   = r_minor_neg ? (r_y0 - off) : (r_y0 + off);
        major_x   = r_dir ? (r_x0 - r_k) : (r_x0 + r_k);
        major_y_c = r_dir ? (r_y0 - r_k) : (r_y0 + r_k);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lrdda_pkg::ST_IDLE: begin
                if (start_draw) begin
                    n_state = lrdda_pkg::ST_DIV;
                end
            end
            lrdda_pkg::ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = lrdda_pkg::ST_DRAW;
                end
            end
            lrdda_pkg::ST_DRAW: begin
                if (emit && last_now) begin
                    n_state = lrdda_pkg::ST_IDLE;
                end
            end
            default: n_state = lrdda_pkg::ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lrdda_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_width     <= lrdda_pkg::CANVAS_RESET;
            r_height    <= lrdda_pkg::CANVAS_RESET;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (lrdda_pkg::t_cfg_index'(i_cfg_index))
                    lrdda_pkg::CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                    lrdda_pkg::CFG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (start_draw) begin
            r_x0        <= i_start_x[PW-1:0];
            r_y0        <= i_start_y[PW-1:0];
            r_major_y   <= major_y;
            r_dir       <= dir;
            r_minor_neg <= minor_neg;
            r_mag_l     <= mag_l;
            r_rem       <= {1'b0, mag_s};
            r_cnt       <= CNT_START;
        end
        if (r_state == lrdda_pkg::ST_DIV) begin
            r_rem <= rem_n;
            r_quo <= {r_quo[QW-2:0], q_bit};
            r_cnt <= r_cnt - CNT_W'(1);
            r_acc <= '0;
            r_k   <= '0;
        end
        if (emit) begin
            r_pix_x <= r_major_y ? minor_x : major_x;
            r_pix_y <= r_major_y ? major_y_c : minor_y;
            r_last  <= last_now;
            r_acc   <= r_acc + AW'(r_quo);
            r_k     <= r_k + PW'(1);
        end
    end

endmodule

### sv/lrdda_checker.sv
// port-level assertions for the line rasterizer, bound to the top level
module lrdda_checker #(
    parameter int SIDE = lrdda_pkg::SIDE_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic [lrdda_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [lrdda_pkg::CFG_W-1:0]     i_cfg_data,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [lrdda_pkg::PIX_W-1:0]     o_pixel_x,
    input logic [lrdda_pkg::PIX_W-1:0]     o_pixel_y,
    input logic                            o_last_pixel
);

    localparam int CW = lrdda_pkg::CFG_W;
    localparam logic [CW-1:0] SIDE_LIM = CW'(SIDE);

    logic [CW-1:0] r_width, r_height;
    logic [CW-1:0] lim_w, lim_h;

    // shadow copy of the canvas registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= lrdda_pkg::CANVAS_RESET;
            r_height <= lrdda_pkg::CANVAS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (lrdda_pkg::t_cfg_index'(i_cfg_index))
                lrdda_pkg::CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                lrdda_pkg::CFG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign lim_w = lrdda_pkg::canvas_limit(r_width, SIDE_LIM);
    assign lim_h = lrdda_pkg::canvas_limit(r_height, SIDE_LIM);

    // every pixel lies inside the bounding box of two on-canvas endpoints
    a_pixel_x_on_canvas: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_pixel_x} < lim_w))
        else $error("pixel x outside canvas");

    a_pixel_y_on_canvas: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_pixel_y} < lim_h))
        else $error("pixel y outside canvas");

    // an idle block with an empty output cannot produce a pixel in the next cycle
    a_no_pixel_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_in_stall && !o_out_valid) |=> !o_out_valid)
        else $error("pixel appeared without setup and slope division");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_pixel_x) && $stable(o_pixel_y)
             && $stable(o_last_pixel)))
        else $error("stalled pixel transaction changed");

endmodule

bind line_rasterizer_dda_top lrdda_checker #(
    .SIDE(SIDE)
) u_lrdda_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cfg_valid  (i_cfg_valid),
    .o_cfg_ready  (o_cfg_ready),
    .i_cfg_index  (i_cfg_index),
    .i_cfg_data   (i_cfg_data),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_pixel_x    (o_pixel_x),
    .o_pixel_y    (o_pixel_y),
    .o_last_pixel (o_last_pixel)
);

### dv/line_rasterizer_dda_top_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the line rasterizer: directed and random line requests, pixel predictor, checker
module line_rasterizer_dda_top_tb;

    localparam int IN_W           = lrdda_pkg::IN_W;
    localparam int PIX_W          = lrdda_pkg::PIX_W;
    localparam int CFG_W          = lrdda_pkg::CFG_W;
    localparam int CFG_IDX_W      = lrdda_pkg::CFG_IDX_W;
    localparam int FRAC           = lrdda_pkg::FRAC_BITS_DEF;
    localparam int CANVAS_MAX     = lrdda_pkg::SIDE_DEF;
    // worst line: setup + divider + 63 pixels, plus margin
    localparam int SETTLE_CYCLES  = FRAC + 2 + CANVAS_MAX + 40;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int NUM_PHASES     = 9;

    typedef struct packed {
        logic signed [IN_W-1:0] sx;
        logic signed [IN_W-1:0] sy;
        logic signed [IN_W-1:0] ex;
        logic signed [IN_W-1:0] ey;
    } t_line_req;

    typedef struct packed {
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
        logic             last;
    } t_pixel;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_W-1:0]       i_cfg_data  = '0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_stall;
    logic signed [IN_W-1:0] i_start_x   = '0;
    logic signed [IN_W-1:0] i_start_y   = '0;
    logic signed [IN_W-1:0] i_end_x     = '0;
    logic signed [IN_W-1:0] i_end_y     = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [PIX_W-1:0]       o_pixel_x;
    logic [PIX_W-1:0]       o_pixel_y;
    logic                   o_last_pixel;

    line_rasterizer_dda_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_last_pixel (o_last_pixel)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // canvas as the predictor sees it
    logic [CFG_W-1:0] canvas_w = lrdda_pkg::CANVAS_RESET;
    logic [CFG_W-1:0] canvas_h = lrdda_pkg::CANVAS_RESET;

    t_line_req pend_lines[$];
    t_pixel    exp_pixels[$];
    int        pixel_errors = 0;

    logic [CFG_W-1:0] phase_w [NUM_PHASES] = '{64, 0, 127, 1, 64, 2, 0, 100, 64};
    logic [CFG_W-1:0] phase_h [NUM_PHASES] = '{64, 64, 127, 1, 2, 64, 0, 64, 0};
    int               phase_n [NUM_PHASES] = '{40, 10, 55, 15, 50, 50, 60, 55, 15};

    function automatic bit on_canvas(input int c, input logic [CFG_W-1:0] lim_reg);
        int lim;
        lim = (lim_reg > CANVAS_MAX) ? CANVAS_MAX : int'(lim_reg);
        return (c >= 0) && (c < lim);
    endfunction

    // queue up the pixels one line request should produce
    function automatic void predict_line(input t_line_req req);
        int x0, y0, x1, y1;
        int d_minor, d_major, mag_minor, mag_major, tmp;
        int slope, acc, minor, major, px, py;
        bit y_major;
        t_pixel pix;
        x0 = req.sx;
        y0 = req.sy;
        x1 = req.ex;
        y1 = req.ey;
        if (!on_canvas(x0, canvas_w) || !on_canvas(y0, canvas_h)) return;
        if (!on_canvas(x1, canvas_w) || !on_canvas(y1, canvas_h)) return;
        d_minor   = y1 - y0;
        d_major   = x1 - x0;
        mag_minor = (d_minor < 0) ? -d_minor : d_minor;
        mag_major = (d_major < 0) ? -d_major : d_major;
        y_major   = 1'b0;
        // x wins ties
        if (mag_minor > mag_major) begin
            tmp       = d_minor;
            d_minor   = d_major;
            d_major   = tmp;
            tmp       = mag_minor;
            mag_minor = mag_major;
            mag_major = tmp;
            y_major   = 1'b1;
        end
        if (mag_major == 0) return;
        slope = (mag_minor << FRAC) / mag_major;
        if (d_minor < 0) slope = -slope;
        acc = 0;
        for (int k = 0; k < mag_major; k++) begin
            minor = (acc < 0) ? -((-acc) >>> FRAC) : (acc >>> FRAC);
            major = (d_major < 0) ? -k : k;
            if (y_major) begin
                px = x0 + minor;
                py = y0 + major;
            end else begin
                px = x0 + major;
                py = y0 + minor;
            end
            pix.x    = px[PIX_W-1:0];
            pix.y    = py[PIX_W-1:0];
            pix.last = (k == mag_major - 1);
            exp_pixels.push_back(pix);
            acc += slope;
        end
    endfunction

    function automatic void add_line(input int sx, input int sy, input int ex, input int ey);
        t_line_req req;
        req.sx = sx[IN_W-1:0];
        req.sy = sy[IN_W-1:0];
        req.ex = ex[IN_W-1:0];
        req.ey = ey[IN_W-1:0];
        pend_lines.push_back(req);
    endfunction

    function automatic int near_coord(input int c, input int lim);
        int v;
        v = c + int'($urandom_range(0, 10)) - 5;
        if (v < 0) v = 0;
        if (v > lim - 1) v = lim - 1;
        return v;
    endfunction

    function automatic void add_random_line(input logic [CFG_W-1:0] w_reg,
                                            input logic [CFG_W-1:0] h_reg);
        int lw, lh, sx, sy, ex, ey, pick, field, bad;
        lw   = (w_reg > CANVAS_MAX) ? CANVAS_MAX : int'(w_reg);
        lh   = (h_reg > CANVAS_MAX) ? CANVAS_MAX : int'(h_reg);
        pick = $urandom_range(0, 99);
        if (lw == 0 || lh == 0 || pick < 12) begin
            // raw noise over all eight bits
            add_line($urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 255));
            return;
        end
        sx = $urandom_range(0, lw - 1);
        sy = $urandom_range(0, lh - 1);
        if (pick < 20) begin
            ex = sx;
            ey = sy;
        end else if (pick < 50) begin
            ex = near_coord(sx, lw);
            ey = near_coord(sy, lh);
        end else begin
            ex = $urandom_range(0, lw - 1);
            ey = $urandom_range(0, lh - 1);
        end
        if (pick >= 20 && pick < 28) begin
            // one coordinate just off the canvas or at a field extreme
            field = $urandom_range(0, 3);
            case ($urandom_range(0, 3))
                0:       bad = -1;
                1:       bad = -128;
                2:       bad = 127;
                default: bad = (field % 2 == 0) ? lw : lh;
            endcase
            case (field)
                0:       sx = bad;
                1:       sy = bad;
                2:       ex = bad;
                default: ey = bad;
            endcase
        end
        add_line(sx, sy, ex, ey);
    endfunction

    task automatic add_directed();
        add_line(0, 0, 63, 63);
        add_line(63, 63, 0, 0);
        add_line(0, 63, 63, 0);
        add_line(63, 0, 0, 63);
        add_line(0, 5, 63, 5);
        add_line(63, 5, 0, 5);
        add_line(5, 0, 5, 63);
        add_line(5, 63, 5, 0);
        add_line(10, 10, 10, 10);
        add_line(0, 0, 0, 0);
        add_line(63, 63, 63, 63);
        add_line(-1, 3, 4, 4);
        add_line(3, 3, 4, -1);
        add_line(-128, 0, 5, 5);
        add_line(0, 127, 5, 5);
        add_line(64, 0, 5, 5);
        add_line(5, 5, 5, 64);
        add_line(10, 0, 3, 50);
        add_line(0, 10, 50, 3);
        add_line(0, 0, 20, 20);
        add_line(20, 0, 0, 20);
        add_line(0, 0, 1, 0);
        add_line(0, 0, 0, 1);
        add_line(30, 30, 29, 31);
    endtask

    task automatic write_canvas_reg(input lrdda_pkg::t_cfg_index idx,
                                    input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == lrdda_pkg::CFG_SCREEN_WIDTH) canvas_w = val;
        else canvas_h = val;
    endtask

    task automatic wait_drained();
        while (pend_lines.size() != 0 || i_in_valid || exp_pixels.size() != 0)
            @(posedge i_clk);
    endtask

    // request driver: bursts of transactions separated by random gaps
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        t_line_req nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left <= 1;
            gap_left   <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_line('{i_start_x, i_start_y, i_end_x, i_end_y});
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left   <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (pend_lines.size() != 0) begin
                    nxt = pend_lines.pop_front();
                    i_start_x  <= nxt.sx;
                    i_start_y  <= nxt.sy;
                    i_end_x    <= nxt.ex;
                    i_end_y    <= nxt.ey;
                    i_in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 16);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output backpressure: a random pattern, chosen anew when stall_cycle[5:0] wraps
    t_stall_mode stall_mode  = STALL_NONE;
    logic [15:0] stall_cycle = '0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_cycle <= '0;
            stall_mode  <= STALL_NONE;
        end else begin
            stall_cycle <= stall_cycle + 16'd1;
            if (stall_cycle[5:0] == 6'h3f) stall_mode <= t_stall_mode'($urandom_range(0, 3));
            case (stall_mode)
                STALL_NONE:  i_out_stall <= 1'b0;
                STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                default:     i_out_stall <= stall_cycle[2];
            endcase
        end
    end

    // pixel monitor
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (exp_pixels.size() == 0) begin
                if (pixel_errors < 10)
                    $display("%0t unexpected pixel x=%0d y=%0d last=%0d", $realtime,
                             o_pixel_x, o_pixel_y, o_last_pixel);
                pixel_errors++;
            end else begin
                want = exp_pixels.pop_front();
                if (want.x !== o_pixel_x || want.y !== o_pixel_y
                    || want.last !== o_last_pixel) begin
                    if (pixel_errors < 10)
                        $display("%0t mismatch exp x,y,last %0d,%0d,%0d got %0d,%0d,%0d",
                                 $realtime, want.x, want.y, want.last,
                                 o_pixel_x, o_pixel_y, o_last_pixel);
                    pixel_errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("line_rasterizer_dda_top regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        phase_w[6] = CFG_W'($urandom_range(1, 64));
        phase_h[6] = CFG_W'($urandom_range(1, 64));
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            write_canvas_reg(lrdda_pkg::CFG_SCREEN_WIDTH, phase_w[p]);
            write_canvas_reg(lrdda_pkg::CFG_SCREEN_HEIGHT, phase_h[p]);
            if (p == 0) add_directed();
            for (int i = 0; i < phase_n[p]; i++) add_random_line(canvas_w, canvas_h);
        end
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pixel_errors == 0 && exp_pixels.size() == 0) begin
            $display("line_rasterizer_dda_top regression: pass");
        end else begin
            $display("line_rasterizer_dda_top regression: fail");
        end
        $finish;
    end

endmodule

### sim.f
sv/lrdda_pkg.sv
sv/line_rasterizer_dda_top.sv
sv/lrdda_checker.sv
dv/line_rasterizer_dda_top_tb.sv
